[hw/rtl/jerk_profile_step_generator_core_assert.svh]
// assertion helpers used by the checker
`ifndef JERK_PROFILE_STEP_GENERATOR_CORE_ASSERT_SVH
`define JERK_PROFILE_STEP_GENERATOR_CORE_ASSERT_SVH

// property checked while reset is low
`define JPSG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("jpsg assertion failed");

// property checked on every edge, reset included
`define JPSG_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("jpsg assertion failed");

`endif

[hw/rtl/jpsg_pkg.sv]
`default_nettype none
package jpsg_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 32;

   // one microstep is 8192 sub-steps, pulse at half of it
   localparam logic signed [15:0] MICROSTEP      = 16'sd8192;
   localparam logic signed [15:0] HALF_MICROSTEP = 16'sd4096;

   // acceleration to velocity: round by half, then divide by 512
   localparam int ACCEL_SHIFT = 9;
   localparam logic signed [16:0] ACCEL_ROUND = 17'sd256;
   localparam logic signed [16:0] ACCEL_TRUNC = 17'sd511;

   // start-of-segment velocity term: (jerk*5 + 17) / (32*512)
   localparam logic signed [19:0] VEL_BIAS  = 20'sd17;
   localparam int VEL_SHIFT = 14;
   localparam logic signed [19:0] VEL_TRUNC = 20'sd16383;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_PUSH = 1'b1
   } kind_type;

   typedef struct packed {
      logic signed [15:0] jerk;
      logic [15:0]        duration;
   } seg_entry_type;

   typedef struct packed {
      logic queue_empty;
      logic push_accepted;
      logic direction_positive;
      logic step_pulse;
   } rsp_fields_type;

endpackage
`default_nettype wire

[hw/rtl/jpsg_ram.sv]
`default_nettype none
module jpsg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/jerk_profile_step_generator_core.sv]
// channel | ports  | beat fields (lsb first)
// --------+--------+----------------------------------------------------------
// input   | req_*  | tdata: seg_duration[15:0], seg_jerk[31:16]; tuser: kind
// result  | rsp_*  | tdata: step_pulse, direction_positive, push_accepted,
//         |        |        queue_empty, zero pad [7:4]
//
// one beat per cycle unless stalled; each beat gives exactly one result beat
// from accept to result: stage one reads the head segment from the queue ram,
// the second stage updates the motion state and loads the output register
// synchronous active-high reset clears indices and motion state; queue ram
// content is not cleared and needs no sweep
// a stalled result holds both stages; req_tready is low once stage one is full
`default_nettype none
module jerk_profile_step_generator_core #(
   parameter int QUEUE_DEPTH = jpsg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // seg_duration, seg_jerk
   input  wire logic        req_tuser,   // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // step_pulse, direction_positive,
                                         // push_accepted, queue_empty
);
   import jpsg_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + IDX_W'(1);
      end
      return res;
   endfunction

   // stage one
   logic          s1_valid_ff, s1_valid_in;
   kind_type      s1_kind_ff;
   seg_entry_type s1_entry_ff;
   logic          s1_fwd_ff;
   seg_entry_type s1_fwd_entry_ff;

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_fields_type rsp_data_ff, rsp_data_in;

   // motion and queue state
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic               starting_ff, starting_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic signed [15:0] sp_ff, sp_in;
   logic signed [15:0] vel_ff, vel_in;
   logic signed [15:0] acc_ff, acc_in;
   logic signed [15:0] jerk_ff, jerk_in;

   logic          s1_go, req_take;
   logic [31:0]   ram_rd_data;
   seg_entry_type head;
   logic [IDX_W-1:0] rd_addr, rd_next, wr_next;
   logic          is_tick, is_push, q_empty, q_full, push_ok, serve, pop;
   logic [15:0]   cur_dur;

   logic signed [15:0] j_h, j_half, v_term;
   logic signed [19:0] vx, vq;
   logic signed [15:0] sp_s, v_s, a_s, aj_s;
   logic signed [16:0] at, aq;
   logic signed [15:0] sp_i, v_i, a_i, sp_f;
   logic               pulse, dirp;

   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;

   // head entry, with the push of the previous beat forwarded
   assign head = s1_fwd_ff ? s1_fwd_entry_ff : seg_entry_type'(ram_rd_data);

   assign is_tick = (s1_kind_ff == KIND_TICK);
   assign is_push = (s1_kind_ff == KIND_PUSH);
   assign rd_next = idx_inc(rd_idx_ff);
   assign wr_next = idx_inc(wr_idx_ff);
   assign q_empty = (rd_idx_ff == wr_idx_ff);
   assign q_full  = (wr_next == rd_idx_ff);
   assign push_ok = is_push && !q_full;
   assign serve   = is_tick && !q_empty;
   assign cur_dur = starting_ff ? head.duration : cnt_ff;
   assign pop     = serve && (cur_dur == 16'd0);

   // start-of-segment terms, all truncating toward zero
   assign j_h    = head.jerk;
   assign vx     = ({{4{j_h[15]}}, j_h} <<< 2) + {{4{j_h[15]}}, j_h} + VEL_BIAS;
   assign vq     = vx[19] ? ((vx + VEL_TRUNC) >>> VEL_SHIFT) : (vx >>> VEL_SHIFT);
   assign v_term = vq[15:0];
   assign j_half = (j_h + $signed({15'd0, j_h[15]})) >>> 1;

   always_comb begin
      sp_s = sp_ff;
      v_s  = vel_ff;
      a_s  = acc_ff;
      aj_s = jerk_ff;
      if (serve && starting_ff) begin
         if (head.duration == 16'd0) begin
            sp_s = '0;
            v_s  = '0;
            a_s  = '0;
            aj_s = '0;
         end else begin
            v_s  = vel_ff + v_term;
            a_s  = acc_ff + j_half;
            aj_s = j_h;
         end
      end
   end

   // integration
   assign at   = {a_s[15], a_s} + ACCEL_ROUND;
   assign aq   = at[16] ? ((at + ACCEL_TRUNC) >>> ACCEL_SHIFT) : (at >>> ACCEL_SHIFT);
   assign sp_i = sp_s + v_s;
   assign v_i  = v_s + aq[15:0];
   assign a_i  = a_s + aj_s;
   assign dirp = (sp_i > 16'sd0);

   always_comb begin
      pulse = 1'b0;
      sp_f  = sp_i;
      if (sp_i >= HALF_MICROSTEP) begin
         pulse = 1'b1;
         sp_f  = sp_i - MICROSTEP;
      end else if (sp_i < -HALF_MICROSTEP) begin
         pulse = 1'b1;
         sp_f  = sp_i + MICROSTEP;
      end
   end

   always_comb begin
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      starting_in = starting_ff;
      cnt_in      = cnt_ff;
      sp_in       = sp_ff;
      vel_in      = vel_ff;
      acc_in      = acc_ff;
      jerk_in     = jerk_ff;
      if (s1_go) begin
         if (push_ok) begin
            wr_idx_in = wr_next;
         end
         if (is_tick) begin
            sp_in   = sp_f;
            vel_in  = v_i;
            acc_in  = a_i;
            jerk_in = aj_s;
         end
         if (pop) begin
            rd_idx_in   = rd_next;
            starting_in = 1'b1;
         end else if (serve) begin
            starting_in = 1'b0;
            cnt_in      = cur_dur - 16'd1;
         end
      end
   end

   always_comb begin
      rsp_data_in.step_pulse         = is_tick && pulse;
      rsp_data_in.direction_positive = is_tick && dirp;
      rsp_data_in.push_accepted      = push_ok;
      rsp_data_in.queue_empty        = (rd_idx_in == wr_idx_in);
   end

   // read address follows the pop that retires in this same cycle
   assign rd_addr     = (s1_go && pop) ? rd_next : rd_idx_ff;
   assign s1_valid_in = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_go ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   jpsg_ram #(
      .WIDTH ($bits(seg_entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (s1_go && push_ok),
      .wr_addr (wr_idx_ff),
      .wr_data (s1_entry_ff),
      .rd_en   (req_take),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         starting_ff  <= 1'b1;
         cnt_ff       <= '0;
         sp_ff        <= '0;
         vel_ff       <= '0;
         acc_ff       <= '0;
         jerk_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         starting_ff  <= starting_in;
         cnt_ff       <= cnt_in;
         sp_ff        <= sp_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
         jerk_ff      <= jerk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff           <= kind_type'(req_tuser);
         s1_entry_ff.duration <= req_tdata[15:0];
         s1_entry_ff.jerk     <= req_tdata[31:16];
         // a push retiring now lands on the entry being read
         s1_fwd_ff            <= s1_go && push_ok && (wr_idx_ff == rd_addr);
         s1_fwd_entry_ff      <= s1_entry_ff;
      end
      if (s1_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

endmodule
`default_nettype wire

[hw/rtl/jpsg_checker.sv]
`default_nettype none
`include "jerk_profile_step_generator_core_assert.svh"
module jpsg_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // a result waiting for the sink stays offered
   `JPSG_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // a stored push leaves at least one segment pending
   `JPSG_ASSERT(a_push_nonempty, clock, reset, rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[3])

   // an accepted push never carries a step pulse or a direction
   `JPSG_ASSERT(a_push_no_step, clock, reset, rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[0] && !rsp_tdata[1])

   // reset drops any pending result
   `JPSG_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid)

endmodule

bind jerk_profile_step_generator_core jpsg_checker u_jpsg_checker (.*);
`default_nettype wire

[sim/jerk_profile_step_generator_core_tb.sv]
`default_nettype none
module jerk_profile_step_generator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jpsg_pkg::*;

   localparam int QDEPTH       = QUEUE_DEPTH_DEFAULT;
   localparam int SUB_PER_STEP = 8192;
   localparam int HALF_STEP    = 4096;
   localparam int ACCEL_DIV    = 512;
   localparam int RANDOM_ITEMS = 1300;
   localparam int LONG_HOLD    = 200;
   localparam int QUIET_LIMIT  = 3000;
   localparam int SCRIPT_LEN   = 24;

   localparam rsp_fields_type R_IDLE   = '{queue_empty: 1'b1, default: 1'b0};
   localparam rsp_fields_type R_STORED = '{push_accepted: 1'b1, default: 1'b0};

   typedef struct packed {
      kind_type       kind;
      logic [15:0]    dur;
      logic [15:0]    jerk;
      logic           typed;
      rsp_fields_type want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // seg_duration, seg_jerk
   logic        req_tuser = 1'b0;  // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // step_pulse, direction_positive, push_accepted,
                                   // queue_empty

   // axis state as the block should hold it
   logic [15:0]        seg_len_q  [QDEPTH];
   logic signed [15:0] seg_jerk_q [QDEPTH];
   int                 rd_ptr = 0;
   int                 wr_ptr = 0;
   bit                 fresh_seg = 1'b1;
   logic signed [15:0] m_pos = '0;
   logic signed [15:0] m_vel = '0;
   logic signed [15:0] m_accel = '0;
   logic signed [15:0] m_jerk = '0;

   rsp_fields_type status_due [$];
   int  items_in = 0;
   int  backlog = 0;
   int  mismatches = 0;
   int  stall_cycles = 0;
   bit  calm = 1'b0;
   bit  hold_out = 1'b0;

   // extremes of jerk, stop segments, empty-queue ticks, wrapping overflow
   script_row_type script [SCRIPT_LEN] = '{
      '{KIND_TICK, 16'd0, 16'h0000, 1'b1, R_IDLE},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b1, R_IDLE},
      '{KIND_PUSH, 16'd0, 16'h0000, 1'b1, R_STORED},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b1, R_IDLE},
      '{KIND_PUSH, 16'd5, 16'h7FFF, 1'b1, R_STORED},
      '{KIND_PUSH, 16'd0, 16'h8000, 1'b1, R_STORED},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b1, R_IDLE},
      '{KIND_PUSH, 16'd3, 16'h8000, 1'b1, R_STORED},
      '{KIND_PUSH, 16'd2, 16'h0001, 1'b1, R_STORED},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0},
      '{KIND_TICK, 16'd0, 16'h0000, 1'b0, '0}
   };

   jerk_profile_step_generator_core #(.QUEUE_DEPTH(QDEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic rsp_fields_type advance_axis(kind_type k, logic [15:0] dur,
                                                   logic signed [15:0] jrk);
      rsp_fields_type r;
      int j;
      int p;
      r = '0;
      if (k == KIND_PUSH) begin
         if ((wr_ptr + 1) % QDEPTH != rd_ptr) begin
            seg_len_q[wr_ptr]  = dur;
            seg_jerk_q[wr_ptr] = jrk;
            wr_ptr = (wr_ptr + 1) % QDEPTH;
            r.push_accepted = 1'b1;
         end
      end else begin
         if (rd_ptr != wr_ptr) begin
            if (fresh_seg) begin
               fresh_seg = 1'b0;
               m_jerk  = seg_jerk_q[rd_ptr];
               j       = seg_jerk_q[rd_ptr];
               m_vel   = 16'(int'(m_vel) + ((j * 5 + 17) / 32) / ACCEL_DIV);
               m_accel = 16'(int'(m_accel) + j / 2);
               // zero-length segment is a full stop
               if (seg_len_q[rd_ptr] == 16'd0) begin
                  m_jerk  = '0;
                  m_vel   = '0;
                  m_accel = '0;
                  m_pos   = '0;
               end
            end
            if (seg_len_q[rd_ptr] == 16'd0) begin
               rd_ptr = (rd_ptr + 1) % QDEPTH;
               fresh_seg = 1'b1;
            end else begin
               seg_len_q[rd_ptr] = seg_len_q[rd_ptr] - 16'd1;
            end
         end
         m_pos   = 16'(int'(m_pos) + int'(m_vel));
         m_vel   = 16'(int'(m_vel) + (int'(m_accel) + ACCEL_DIV / 2) / ACCEL_DIV);
         m_accel = 16'(int'(m_accel) + int'(m_jerk));
         p = m_pos;
         r.direction_positive = (p > 0);
         if (p >= HALF_STEP) begin
            r.step_pulse = 1'b1;
            m_pos = 16'(p - SUB_PER_STEP);
         end else if (p < -HALF_STEP) begin
            r.step_pulse = 1'b1;
            m_pos = 16'(p + SUB_PER_STEP);
         end
      end
      r.queue_empty = (rd_ptr == wr_ptr);
      return r;
   endfunction

   function automatic bit idle_ok();
      return !calm && ((items_in / 100) % 3 != 2);
   endfunction

   function automatic logic [15:0] pick_jerk();
      case ($urandom_range(0, 5))
         0, 1, 2: return 16'($urandom_range(0, 4000) - 2000);
         3, 4:    return 16'($urandom_range(0, 32000) - 16000);
         default: return 16'($urandom);
      endcase
   endfunction

   // called and left at a falling edge
   task automatic offer(kind_type k, logic [15:0] dur, logic [15:0] jrk, bit typed,
                        rsp_fields_type want);
      rsp_fields_type got;
      if (idle_ok() && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {jrk, dur};
      do @(posedge clock); while (!req_tready);
      got = advance_axis(k, dur, jrk);
      status_due.push_back(typed ? want : got);
      items_in++;
      @(negedge clock);
   endtask

   task automatic push_seg(logic [15:0] dur, logic [15:0] jrk);
      backlog += int'(dur) + 1;
      offer(KIND_PUSH, dur, jrk, 1'b0, '0);
   endtask

   task automatic tick();
      if (backlog > 0) backlog--;
      offer(KIND_TICK, '0, '0, 1'b0, '0);
   endtask

   task automatic drain();
      while (backlog > 0) tick();
      repeat ($urandom_range(0, 3)) tick();
   endtask

   // ramp segments, optionally ending in a stop, with ticks mixed in
   task automatic run_motion();
      int nseg;
      nseg = $urandom_range(1, 6);
      repeat (nseg) begin
         push_seg(($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 24)),
                  pick_jerk());
         if (backlog > 0 && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, backlog)) tick();
      end
      if ($urandom_range(0, 1) == 1) push_seg(16'd0, pick_jerk());
      drain();
   endtask

   // receiver: short random stalls, one long hold
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_out) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_out = 1'b0;
         end else if (stall_left > 0 && !calm) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_ok() && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 6) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_fields_type'(rsp_tdata[3:0]);
            if (status_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat %b", rsp_tdata);
            end else begin
               want = status_due.pop_front();
               if (got.step_pulse !== want.step_pulse ||
                   got.direction_positive !== want.direction_positive ||
                   got.push_accepted !== want.push_accepted ||
                   got.queue_empty !== want.queue_empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: pulse/dir/acc/empty exp %b %b %b %b got %b %b %b %b",
                              want.step_pulse, want.direction_positive,
                              want.push_accepted, want.queue_empty,
                              got.step_pulse, got.direction_positive,
                              got.push_accepted, got.queue_empty);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= QUIET_LIMIT) begin
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   initial begin
      bit held;
      bit paused;
      int pick;
      held = 1'b0;
      paused = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i])
         offer(script[i].kind, script[i].dur, script[i].jerk, script[i].typed,
               script[i].want);

      while (items_in < RANDOM_ITEMS) begin
         if (!held && items_in >= 400) begin
            held = 1'b1;
            hold_out = 1'b1;
         end
         if (!paused && items_in >= 800) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do @(negedge clock); while (status_due.size() != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            run_motion();
         end else if (pick < 73) begin
            // fill up to or past capacity so pushes may get refused
            drain();
            repeat ($urandom_range(QDEPTH - 1, QDEPTH + 4))
               push_seg(16'($urandom_range(0, 2)), pick_jerk());
            drain();
         end else begin
            repeat ($urandom_range(4, 12)) begin
               if ($urandom_range(0, 1) == 1) push_seg(16'($urandom_range(0, 7)), 16'($urandom));
               else tick();
            end
         end
      end

      // last stretch: no idling, longest segment, then full-range pushes on a stuck head
      calm = 1'b1;
      run_motion();
      drain();
      push_seg(16'hFFFF, pick_jerk());
      repeat (6) tick();
      repeat (QDEPTH + 3) push_seg(16'($urandom), pick_jerk());
      repeat (5) tick();
      req_tvalid <= 1'b0;

      while (status_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire
